[hw/rtl/sva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script variable ALU package
// Shared widths, operation codes, flag positions and generator constants.
// ----------------------------------------------------------------------------
package sva_pkg;

  // Variable file geometry; indexing takes the low bits of a variable number.
  localparam int VAR_COUNT = 128;
  localparam int IDX_W     = $clog2(VAR_COUNT);

  // Field widths of one beat on each channel.
  localparam int OP_W   = 4;
  localparam int CMP_W  = 4;
  localparam int FLAG_W = 4;
  localparam int NUM_W  = 8;
  localparam int DATA_W = 32;

  // Entries that are reloaded from the pad inputs before each instruction.
  localparam logic [IDX_W-1:0] PAD_KEYS_IDX  = IDX_W'(VAR_COUNT - 2);
  localparam logic [IDX_W-1:0] PAD_TOUCH_IDX = IDX_W'(VAR_COUNT - 1);

  // Math step codes.
  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_PAUSE = 4'd4;
  localparam logic [OP_W-1:0] OP_AND   = 4'd5;
  localparam logic [OP_W-1:0] OP_OR    = 4'd6;
  localparam logic [OP_W-1:0] OP_NOT   = 4'd7;
  localparam logic [OP_W-1:0] OP_SHL   = 4'd8;
  localparam logic [OP_W-1:0] OP_SHR   = 4'd9;
  localparam logic [OP_W-1:0] OP_RAND  = 4'd10;

  // Compare step codes.
  localparam logic [CMP_W-1:0] CMP_ASSIGN = 4'd0;
  localparam logic [CMP_W-1:0] CMP_EQ     = 4'd1;
  localparam logic [CMP_W-1:0] CMP_NE     = 4'd2;
  localparam logic [CMP_W-1:0] CMP_GT     = 4'd3;
  localparam logic [CMP_W-1:0] CMP_GE     = 4'd4;
  localparam logic [CMP_W-1:0] CMP_LT     = 4'd5;
  localparam logic [CMP_W-1:0] CMP_LE     = 4'd6;
  localparam logic [CMP_W-1:0] CMP_PASS   = 4'd7;

  // Bit positions within mode_flags.
  localparam int FLAG_B_USED  = 3;
  localparam int FLAG_LITERAL = 2;
  localparam int FLAG_A_IND   = 1;
  localparam int FLAG_B_IND   = 0;

  // Galois LFSR, shifting right.
  localparam logic [DATA_W-1:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [DATA_W-1:0] LFSR_MASK = 32'hD000_0001;

endpackage

[hw/rtl/sva_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script variable ALU channels
// Instruction channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sva_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [sva_pkg::OP_W-1:0]       opcode;
  logic [sva_pkg::CMP_W-1:0]      compare_op;
  logic [sva_pkg::FLAG_W-1:0]     mode_flags;
  logic [sva_pkg::NUM_W-1:0]      index_a;
  logic [sva_pkg::NUM_W-1:0]      index_b;
  logic [sva_pkg::DATA_W-1:0]     immediate;
  logic [sva_pkg::DATA_W-1:0]     pad_keys;
  logic [sva_pkg::DATA_W-1:0]     pad_touch;

  modport source (output valid, opcode, compare_op, mode_flags, index_a, index_b,
                  immediate, pad_keys, pad_touch, input ready);
  modport sink   (input valid, opcode, compare_op, mode_flags, index_a, index_b,
                  immediate, pad_keys, pad_touch, output ready);
endinterface

interface sva_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sva_pkg::DATA_W-1:0] result_value;
  logic                       done_res;

  modport source (output valid, result_value, done_res, input ready);
  modport sink   (input valid, result_value, done_res, output ready);
endinterface

[hw/rtl/script_variable_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script variable ALU
// Runs one script instruction per beat against a 128-entry variable file.
// ----------------------------------------------------------------------------
// An instruction runs from acceptance through a read of operand A, a read of B
// when B is used, a read of the third operand when it names a variable and an
// execute step that gives its result beat, with an indirection step after A or
// B when indirect, then goes back to idle before the next beat is taken. Only
// the A read and the execute step run when only A is read directly and the
// third operand is literal; all steps run when A and B are both indirect and
// the third operand names a variable. A waiting result beat holds the block in
// its final step. The variable file's single read port serves each operand and
// each indirection in turn. The file reads as zero after reset with no clearing
// pass; entries 126 and 127 always return the current instruction's pad values.
// ----------------------------------------------------------------------------
module script_variable_alu (
  input  logic       clk,
  input  logic       rst,
  sva_cmd_if.sink    cmd,
  sva_rsp_if.source  rsp
);

  localparam int IW = sva_pkg::IDX_W;
  localparam int DW = sva_pkg::DATA_W;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_A_DIR = 3'd1;
  localparam logic [2:0] ST_A_IND = 3'd2;
  localparam logic [2:0] ST_B_DIR = 3'd3;
  localparam logic [2:0] ST_B_IND = 3'd4;
  localparam logic [2:0] ST_C_RD  = 3'd5;
  localparam logic [2:0] ST_EXEC  = 3'd6;

  logic [2:0]                       state;
  logic [2:0]                       state_next;

  // Latched instruction.
  logic [sva_pkg::OP_W-1:0]         op_q;
  logic [sva_pkg::CMP_W-1:0]        cmp_q;
  logic [sva_pkg::FLAG_W-1:0]       flags_q;
  logic [IW-1:0]                    ib_q;
  logic [DW-1:0]                    imm_q;
  logic [DW-1:0]                    pad_keys_q;
  logic [DW-1:0]                    pad_touch_q;

  // Gathered operands.
  logic [IW-1:0]                    a_num;
  logic [DW-1:0]                    a_val;
  logic [DW-1:0]                    b_val;
  logic [DW-1:0]                    c_val;
  logic [DW-1:0]                    lfsr;

  // Variable file and its read port.
  logic [DW-1:0]                    mem [sva_pkg::VAR_COUNT];
  logic [sva_pkg::VAR_COUNT-1:0]    vld;
  logic [DW-1:0]                    mem_q;
  logic [IW-1:0]                    rd_addr;
  logic [IW-1:0]                    rd_addr_q;
  logic [DW-1:0]                    rd_data;

  logic                             b_used;
  logic                             literal;
  logic [IW-1:0]                    imm_idx;
  logic [IW-1:0]                    rd_idx;
  logic [2:0]                       after_b;
  logic [2:0]                       after_a;

  logic [DW-1:0]                    c_op;
  logic [DW-1:0]                    lfsr_next;
  logic [DW-1:0]                    b_new;
  logic                             math_ok;
  logic                             cmp_ok;
  logic [DW-1:0]                    res;
  logic                             out_free;
  logic                             do_write;

  assign b_used  = flags_q[sva_pkg::FLAG_B_USED];
  assign literal = flags_q[sva_pkg::FLAG_LITERAL];
  assign imm_idx = imm_q[IW-1:0];
  assign rd_idx  = rd_data[IW-1:0];
  assign after_b = literal ? ST_EXEC : ST_C_RD;
  assign after_a = b_used ? ST_B_DIR : after_b;

  assign cmd.ready = (state == ST_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  // Read data: pad entries bypass the array, unwritten entries read as zero.
  always_comb begin
    priority if (rd_addr_q == sva_pkg::PAD_KEYS_IDX) begin
      rd_data = pad_keys_q;
    end else if (rd_addr_q == sva_pkg::PAD_TOUCH_IDX) begin
      rd_data = pad_touch_q;
    end else if (vld[rd_addr_q]) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

  // Read address and next state for each step of operand gathering.
  always_comb begin
    rd_addr    = imm_idx;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        rd_addr = cmd.index_a[IW-1:0];
        if (cmd.valid) state_next = ST_A_DIR;
      end
      ST_A_DIR: begin
        if (flags_q[sva_pkg::FLAG_A_IND]) begin
          rd_addr    = rd_idx;
          state_next = ST_A_IND;
        end else begin
          rd_addr    = b_used ? ib_q : imm_idx;
          state_next = after_a;
        end
      end
      ST_A_IND: begin
        rd_addr    = b_used ? ib_q : imm_idx;
        state_next = after_a;
      end
      ST_B_DIR: begin
        if (flags_q[sva_pkg::FLAG_B_IND]) begin
          rd_addr    = rd_idx;
          state_next = ST_B_IND;
        end else begin
          state_next = after_b;
        end
      end
      ST_B_IND: state_next = after_b;
      ST_C_RD:  state_next = ST_EXEC;
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Math step on B and the third operand.
  always_comb begin
    c_op      = literal ? imm_q : c_val;
    lfsr_next = {1'b0, lfsr[DW-1:1]} ^ (lfsr[0] ? sva_pkg::LFSR_MASK : '0);
    math_ok   = 1'b1;
    b_new     = b_val;
    unique case (op_q)
      sva_pkg::OP_ADD:   b_new = b_val + c_op;
      sva_pkg::OP_SUB:   b_new = b_val - c_op;
      sva_pkg::OP_PAUSE: b_new = b_val;
      sva_pkg::OP_AND:   b_new = b_val & c_op;
      sva_pkg::OP_OR:    b_new = b_val | c_op;
      sva_pkg::OP_NOT:   b_new = ~c_op;
      sva_pkg::OP_SHL:   b_new = (|c_op[DW-1:5]) ? '0 : (b_val << c_op[4:0]);
      sva_pkg::OP_SHR:   b_new = (|c_op[DW-1:5]) ? '0 : (b_val >> c_op[4:0]);
      sva_pkg::OP_RAND:  b_new = lfsr_next & c_op;
      default:           math_ok = 1'b0;
    endcase
  end

  // Compare step between A and the new B.
  always_comb begin
    cmp_ok = 1'b1;
    res    = '0;
    unique case (cmp_q)
      sva_pkg::CMP_ASSIGN: res = b_new;
      sva_pkg::CMP_EQ:     res = DW'(a_val == b_new);
      sva_pkg::CMP_NE:     res = DW'(a_val != b_new);
      sva_pkg::CMP_GT:     res = DW'(a_val >  b_new);
      sva_pkg::CMP_GE:     res = DW'(a_val >= b_new);
      sva_pkg::CMP_LT:     res = DW'(a_val <  b_new);
      sva_pkg::CMP_LE:     res = DW'(a_val <= b_new);
      sva_pkg::CMP_PASS:   res = b_new;
      default:             cmp_ok = 1'b0;
    endcase
  end

  assign do_write = (state == ST_EXEC) && out_free && math_ok && cmp_ok &&
                    (cmp_q == sva_pkg::CMP_ASSIGN);

  // Variable file array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (do_write) mem[a_num] <= b_new;
    mem_q     <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Control state, valid bits, generator and result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      lfsr      <= sva_pkg::LFSR_SEED;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC && out_free) begin
        rsp.valid <= 1'b1;
        if (math_ok && op_q == sva_pkg::OP_RAND) lfsr <= lfsr_next;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (do_write) vld[a_num] <= 1'b1;
    end
  end

  // Instruction capture, operand registers and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          op_q        <= cmd.opcode;
          cmp_q       <= cmd.compare_op;
          flags_q     <= cmd.mode_flags;
          ib_q        <= cmd.index_b[IW-1:0];
          imm_q       <= cmd.immediate;
          pad_keys_q  <= cmd.pad_keys;
          pad_touch_q <= cmd.pad_touch;
          a_num       <= cmd.index_a[IW-1:0];
          b_val       <= '0;
        end
      end
      ST_A_DIR: begin
        if (flags_q[sva_pkg::FLAG_A_IND]) a_num <= rd_idx;
        else                              a_val <= rd_data;
      end
      ST_A_IND: a_val <= rd_data;
      ST_B_DIR: begin
        if (!flags_q[sva_pkg::FLAG_B_IND]) b_val <= rd_data;
      end
      ST_B_IND: b_val <= rd_data;
      ST_C_RD:  c_val <= rd_data;
      ST_EXEC: begin
        if (out_free) begin
          rsp.result_value <= (math_ok && cmp_ok) ? res : '0;
          rsp.done_res     <= math_ok && cmp_ok;
        end
      end
      default: ;
    endcase
  end

endmodule

[dv/script_variable_alu_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script variable ALU testbench
// Drives script instructions into the ALU and checks every result beat
// against a shadow copy of the variable file and the random generator. A short
// directed list is followed by random traffic with random gaps on both sides,
// a burst with no gaps, and a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module script_variable_alu_test;
  import sva_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE_CYCLES = 12;

  // Mode flag masks built from the bit positions in the package.
  localparam logic [FLAG_W-1:0] F_NONE = '0;
  localparam logic [FLAG_W-1:0] F_BUSE = FLAG_W'(1 << FLAG_B_USED);
  localparam logic [FLAG_W-1:0] F_LIT  = FLAG_W'(1 << FLAG_LITERAL);
  localparam logic [FLAG_W-1:0] F_AIND = FLAG_W'(1 << FLAG_A_IND);
  localparam logic [FLAG_W-1:0] F_BIND = FLAG_W'(1 << FLAG_B_IND);

  // Codes that the block does not know.
  localparam logic [OP_W-1:0]  OP_BAD       = 4'd2;
  localparam logic [OP_W-1:0]  OP_BAD_TOP   = 4'hF;
  localparam logic [CMP_W-1:0] CMP_BAD      = 4'd8;
  localparam logic [CMP_W-1:0] CMP_BAD_TOP  = 4'hF;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CMP_W-1:0]  compare_op;
    logic [FLAG_W-1:0] mode_flags;
    logic [NUM_W-1:0]  index_a;
    logic [NUM_W-1:0]  index_b;
    logic [DATA_W-1:0] immediate;
    logic [DATA_W-1:0] pad_keys;
    logic [DATA_W-1:0] pad_touch;
  } instr_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              done;
  } outcome_t;

  logic clk;
  logic rst;

  sva_cmd_if cmd_ch ();
  sva_rsp_if rsp_ch ();

  script_variable_alu u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow state of the block and the results still owed by it.
  logic [DATA_W-1:0] shadow_vars [VAR_COUNT];
  logic [DATA_W-1:0] shadow_lfsr;
  outcome_t          pending_results [$];

  int  err_count = 0;
  int  cycle_count = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_executed = 0;
  int  n_rejected = 0;
  int  rsp_hold = 0;
  bit  cmd_gaps_off = 1'b0;
  bit  rsp_gaps_off = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Executes one instruction on the shadow state and returns its outcome.
  function automatic outcome_t run_instruction(input instr_t it);
    logic [IDX_W-1:0]  a_num;
    logic [IDX_W-1:0]  b_num;
    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic [DATA_W-1:0] c_val;
    outcome_t          o;
    bit                known;
    o     = '0;
    known = 1'b1;
    // The pad entries are refreshed before any operand is read.
    shadow_vars[PAD_KEYS_IDX]  = it.pad_keys;
    shadow_vars[PAD_TOUCH_IDX] = it.pad_touch;
    a_num = it.index_a[IDX_W-1:0];
    if (it.mode_flags[FLAG_A_IND])
      a_num = shadow_vars[a_num][IDX_W-1:0];
    a_val = shadow_vars[a_num];
    b_val = '0;
    if (it.mode_flags[FLAG_B_USED]) begin
      b_num = it.index_b[IDX_W-1:0];
      if (it.mode_flags[FLAG_B_IND])
        b_num = shadow_vars[b_num][IDX_W-1:0];
      b_val = shadow_vars[b_num];
    end
    c_val = it.mode_flags[FLAG_LITERAL] ? it.immediate
                                        : shadow_vars[it.immediate[IDX_W-1:0]];
    // Math step.
    case (it.opcode)
      OP_ADD:   b_val = b_val + c_val;
      OP_SUB:   b_val = b_val - c_val;
      OP_PAUSE: b_val = b_val;
      OP_AND:   b_val = b_val & c_val;
      OP_OR:    b_val = b_val | c_val;
      OP_NOT:   b_val = ~c_val;
      OP_SHL:   b_val = (c_val >= DATA_W) ? '0 : (b_val << c_val);
      OP_SHR:   b_val = (c_val >= DATA_W) ? '0 : (b_val >> c_val);
      OP_RAND: begin
        shadow_lfsr = {1'b0, shadow_lfsr[DATA_W-1:1]} ^
                      (shadow_lfsr[0] ? LFSR_MASK : '0);
        b_val = shadow_lfsr & c_val;
      end
      default:  known = 1'b0;
    endcase
    if (!known)
      return o;
    // Compare step; only an assignment writes back.
    o.done = 1'b1;
    case (it.compare_op)
      CMP_ASSIGN: begin
        o.value = b_val;
        shadow_vars[a_num] = b_val;
      end
      CMP_EQ:   o.value = DATA_W'(a_val == b_val);
      CMP_NE:   o.value = DATA_W'(a_val != b_val);
      CMP_GT:   o.value = DATA_W'(a_val > b_val);
      CMP_GE:   o.value = DATA_W'(a_val >= b_val);
      CMP_LT:   o.value = DATA_W'(a_val < b_val);
      CMP_LE:   o.value = DATA_W'(a_val <= b_val);
      CMP_PASS: o.value = b_val;
      default:  o = '0;
    endcase
    return o;
  endfunction

  function automatic int draw_gap(input bit off);
    return off ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic instr_t mk(input logic [OP_W-1:0] op, input logic [CMP_W-1:0] cmp,
                                input logic [FLAG_W-1:0] flags,
                                input logic [NUM_W-1:0] ia, input logic [NUM_W-1:0] ib,
                                input logic [DATA_W-1:0] imm,
                                input logic [DATA_W-1:0] pk, input logic [DATA_W-1:0] pt);
    return '{op, cmp, flags, ia, ib, imm, pk, pt};
  endfunction

  // Data words lean towards corner values and small shift amounts.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 32'h8000_0000;
          default: return 32'h0000_0001;
        endcase
      end
      1:       return DATA_W'($urandom_range(0, 40));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Variable numbers now and then land on the pad entries, in either half.
  function automatic logic [NUM_W-1:0] pick_index();
    if ($urandom_range(0, 7) == 0)
      return {1'($urandom), PAD_KEYS_IDX[IDX_W-1:1], 1'($urandom)};
    return NUM_W'($urandom);
  endfunction

  // Mostly known codes with random operands; now and then any code at all.
  function automatic instr_t random_instr();
    instr_t it;
    it.opcode = OP_W'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      while (!(it.opcode == OP_ADD || it.opcode == OP_SUB || it.opcode == OP_PAUSE ||
               it.opcode == OP_AND || it.opcode == OP_OR || it.opcode == OP_NOT ||
               it.opcode == OP_SHL || it.opcode == OP_SHR || it.opcode == OP_RAND))
        it.opcode = OP_W'($urandom);
    end
    it.compare_op = ($urandom_range(0, 9) == 0) ? CMP_W'($urandom)
                                                : CMP_W'($urandom_range(CMP_ASSIGN, CMP_PASS));
    it.mode_flags = FLAG_W'($urandom);
    it.index_a    = pick_index();
    it.index_b    = pick_index();
    it.immediate  = rand_word();
    it.pad_keys   = rand_word();
    it.pad_touch  = rand_word();
    return it;
  endfunction

  // Offers one instruction beat and books its expected result on acceptance.
  task automatic send_instr(input instr_t it);
    int gap;
    gap = draw_gap(cmd_gaps_off);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= it.opcode;
    cmd_ch.compare_op <= it.compare_op;
    cmd_ch.mode_flags <= it.mode_flags;
    cmd_ch.index_a    <= it.index_a;
    cmd_ch.index_b    <= it.index_b;
    cmd_ch.immediate  <= it.immediate;
    cmd_ch.pad_keys   <= it.pad_keys;
    cmd_ch.pad_touch  <= it.pad_touch;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_results.push_back(run_instruction(it));
    n_sent++;
  endtask

  // Stops offering and waits until every booked result has been seen.
  task automatic wait_results_drained();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: a random stall before each beat, or a long one on request.
  initial begin : result_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b1);
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (rsp_hold > 0) ? rsp_hold : draw_gap(rsp_gaps_off);
      rsp_hold = 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Compares each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: value %h done %b", $time,
                 rsp_ch.result_value, rsp_ch.done_res);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.result_value !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   rsp_ch.result_value);
          err_count++;
        end
        if (rsp_ch.done_res !== want.done) begin
          $display("%0t: done_res expected %b actual %b", $time, want.done,
                   rsp_ch.done_res);
          err_count++;
        end
        n_checked++;
        if (want.done)
          n_executed++;
        else
          n_rejected++;
      end
    end
  end

  // Every operation, every compare, index wrap, large shifts, random steps,
  // unknown codes and the pad entries, in a fixed order.
  task automatic test_directed();
    instr_t list [$];
    list.push_back(mk(OP_ADD, CMP_ASSIGN, F_NONE, 8'h00, 8'h00, '0, '0, '0));
    list.push_back(mk(OP_ADD, CMP_ASSIGN, F_LIT, 8'd5, 8'd0, '1, 32'h1, 32'h2));
    // Index 133 wraps onto variable 5.
    list.push_back(mk(OP_ADD, CMP_ASSIGN, F_BUSE | F_LIT, 8'd5, 8'd133, 32'h1, '0, '0));
    list.push_back(mk(OP_SUB, CMP_ASSIGN, F_BUSE | F_LIT, 8'd6, 8'd6, 32'h1, '0, '0));
    list.push_back(mk(OP_NOT, CMP_ASSIGN, F_LIT, 8'd7, 8'd0, 32'hFFFF_FF8C, '0, '0));
    // Third operand by number, with junk in the upper bits.
    list.push_back(mk(OP_AND, CMP_PASS, F_BUSE, 8'd0, 8'd6, 32'hFFFF_FF07, '0, '0));
    list.push_back(mk(OP_OR, CMP_ASSIGN, F_BUSE | F_LIT | F_AIND, 8'd7, 8'd5,
                      32'h8000_0000, '0, '0));
    list.push_back(mk(OP_SHL, CMP_PASS, F_BUSE | F_LIT, 8'd0, 8'd6, 32'd31, '0, '0));
    list.push_back(mk(OP_SHL, CMP_PASS, F_BUSE | F_LIT, 8'd0, 8'd6, 32'd32, '0, '0));
    list.push_back(mk(OP_SHR, CMP_PASS, F_BUSE | F_LIT, 8'd0, 8'd6, 32'd31, '0, '0));
    list.push_back(mk(OP_SHR, CMP_PASS, F_BUSE | F_LIT, 8'd0, 8'd6, '1, '0, '0));
    list.push_back(mk(OP_PAUSE, CMP_PASS, F_BUSE | F_BIND, 8'd0, 8'd7, '0, '0, '0));
    list.push_back(mk(OP_RAND, CMP_ASSIGN, F_LIT, 8'd8, 8'd0, '1, '0, '0));
    // The generator still moves on when the compare code is unknown.
    list.push_back(mk(OP_RAND, CMP_BAD_TOP, F_LIT, 8'd9, 8'd0, '1, '0, '0));
    list.push_back(mk(OP_RAND, CMP_PASS, F_LIT, 8'd9, 8'd0, '1, '0, '0));
    list.push_back(mk(OP_BAD, CMP_ASSIGN, F_LIT, 8'd10, 8'd0, 32'h55, '0, '0));
    list.push_back(mk(OP_ADD, CMP_BAD, F_LIT, 8'd10, 8'd0, 32'h55, '0, '0));
    // An assignment to a pad entry lasts only until the next instruction.
    list.push_back(mk(OP_ADD, CMP_ASSIGN, F_LIT, 8'hFE, 8'd0, 32'h1234, 32'hAAAA, '0));
    list.push_back(mk(OP_PAUSE, CMP_PASS, F_BUSE, 8'd0, 8'd126, '0, 32'h55, '0));
    list.push_back(mk(OP_ADD, CMP_EQ, F_AIND | F_LIT, 8'd127, 8'd0, '0, '0, 32'h105));
    list.push_back(mk(OP_ADD, CMP_NE, F_LIT, 8'd6, 8'd0, '1, '0, '0));
    list.push_back(mk(OP_ADD, CMP_GT, F_LIT, 8'd6, 8'd0, 32'h1, '0, '0));
    list.push_back(mk(OP_ADD, CMP_GE, F_LIT, 8'd6, 8'd0, '0, '0, '0));
    list.push_back(mk(OP_ADD, CMP_LT, F_LIT, 8'd6, 8'd0, '1, '0, '0));
    list.push_back(mk(OP_ADD, CMP_LE, F_BUSE, 8'd134, 8'd255, '1, '0, '1));
    list.push_back(mk(OP_BAD_TOP, CMP_BAD_TOP, F_BUSE | F_LIT | F_AIND | F_BIND,
                      8'hFF, 8'hFF, '1, '1, '1));
    foreach (list[i])
      send_instr(list[i]);
    wait_results_drained();
  endtask

  // Random traffic in blocks; some blocks run without gaps, and the sender
  // waits for every result at the end of each block.
  task automatic test_random_traffic(input int blocks, input int per_block);
    for (int b = 0; b < blocks; b++) begin
      cmd_gaps_off = ($urandom_range(0, 3) == 0);
      rsp_gaps_off = ($urandom_range(0, 3) == 0);
      repeat (per_block) send_instr(random_instr());
      wait_results_drained();
    end
    cmd_gaps_off = 1'b0;
    rsp_gaps_off = 1'b0;
  endtask

  // Both sides at full rate.
  task automatic test_back_to_back(input int count);
    cmd_gaps_off = 1'b1;
    rsp_gaps_off = 1'b1;
    repeat (count) send_instr(random_instr());
    wait_results_drained();
    cmd_gaps_off = 1'b0;
    rsp_gaps_off = 1'b0;
  endtask

  // The result side holds off for a long stretch while instructions keep
  // coming, so the block backs up and stalls its input.
  task automatic test_backpressure(input int count);
    cmd_gaps_off = 1'b1;
    rsp_hold     = 200;
    repeat (count) send_instr(random_instr());
    wait_results_drained();
    cmd_gaps_off = 1'b0;
  endtask

  // Reset, then the tests in turn.
  initial begin
    rst                  = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.opcode        = '0;
    cmd_ch.compare_op    = '0;
    cmd_ch.mode_flags    = '0;
    cmd_ch.index_a       = '0;
    cmd_ch.index_b       = '0;
    cmd_ch.immediate     = '0;
    cmd_ch.pad_keys      = '0;
    cmd_ch.pad_touch     = '0;
    foreach (shadow_vars[i])
      shadow_vars[i] = '0;
    shadow_lfsr = LFSR_SEED;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(16, 50);
    test_back_to_back(200);
    test_backpressure(30);
    test_random_traffic(1, 60);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d instructions; %0d results checked, %0d executed, %0d unknown codes.",
             n_sent, n_checked, n_executed, n_rejected);
    $display("Traffic covered random gaps, full-rate bursts and a long result stall.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sva_pkg.sv
hw/rtl/sva_if.sv
hw/rtl/script_variable_alu.sv
dv/script_variable_alu_test.sv
